@@ hdl/wscu_pkg.sv @@
package wscu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 8;
  localparam int unsigned KeyW    = 32;

  // Result tdata: payload_byte, frame_status, payload_length, zero fill
  localparam int unsigned OutDataW = 24;

  localparam logic [ByteW-1:0] FirstByte = 8'h88;
  localparam logic [ByteW-1:0] MaskBit   = 8'h80;
  localparam logic [ByteW-1:0] LenBits   = 8'h7f;
  localparam logic [LenW-1:0]  MaxLen    = 7'd125;
  localparam logic [PosW-1:0]  HdrBytes  = 8'd6;
  localparam logic [PosW-1:0]  PosMax    = 8'd255;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY      = 3'd0,
    ST_DONE      = 3'd1,
    ST_BAD_FIRST = 3'd2,
    ST_UNMASKED  = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_NO_MASK   = 3'd5,
    ST_TRUNC     = 3'd6
  } status_t;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    status_t          frame_status;
    logic [LenW-1:0]  payload_length;
  } result_t;

endpackage

@@ hdl/websocket_close_frame_unmask.sv @@
// Checks and unmasks one client WebSocket close frame per received block, a
// byte per request. Byte 0 must be 0x88, byte 1 must carry the mask bit and
// a length of at most 125, bytes 2..5 are the mask key, and each payload
// byte comes out XORed with key byte (index mod 4). Every input byte yields
// exactly one result: out_tuser flags a payload byte, and frame_status gives
// 0 busy, 1 done, 2 bad first byte, 3 unmasked, 4 too long, 5 no mask,
// 6 truncated. After an error the rest of the block reports busy; in_tlast
// ends the block and returns the parser to its reset state. Rate is one byte
// per clock while out_tready is high; each byte passes one input register,
// then the parser logic into the result register. Payload bytes already
// sent before a truncation are not taken back.
module websocket_close_frame_unmask (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // block_end
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wscu_pkg::OutDataW-1:0]  out_tdata,  // [7:0] payload_byte,
                                                     // [10:8] frame_status,
                                                     // [17:11] payload_length
  output logic                           out_tuser   // payload_valid
);

  // input register
  logic                        s1_valid_r;
  logic [wscu_pkg::ByteW-1:0]  s1_byte_r;
  logic                        s1_last_r;
  logic                        s1_go;

  // result register
  logic                        out_valid_r;
  wscu_pkg::result_t           out_res_r;
  wscu_pkg::result_t           res;

  // stage 1 moves on when the result slot is free or being drained
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  wscu_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .data_byte (s1_byte_r),
    .block_end (s1_last_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.payload_valid;
  assign out_tdata  = {6'b000000, out_res_r.payload_length,
                       out_res_r.frame_status, out_res_r.payload_byte};

endmodule

@@ hdl/wscu_parse.sv @@
module wscu_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [wscu_pkg::ByteW-1:0] data_byte,
  input  logic                      block_end,
  output wscu_pkg::result_t         result
);

  logic [wscu_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [wscu_pkg::LenW-1:0] flen_r, flen_nxt;
  logic [wscu_pkg::KeyW-1:0] key_r, key_nxt;
  logic                      err_r, err_nxt;

  logic [wscu_pkg::PosW-1:0] pay_end;
  logic [1:0]                hdr_idx;
  logic [1:0]                pay_idx;
  logic [wscu_pkg::ByteW-1:0] key_byte;

  assign pay_end  = wscu_pkg::HdrBytes + {1'b0, flen_r};
  assign hdr_idx  = pos_r[1:0] - 2'd2;      // mask byte pos-2
  assign pay_idx  = pos_r[1:0] + 2'd2;      // (pos-6) mod 4
  assign key_byte = key_r[{pay_idx, 3'b000} +: wscu_pkg::ByteW];

  always_comb begin
    pos_nxt  = pos_r;
    flen_nxt = flen_r;
    key_nxt  = key_r;
    err_nxt  = err_r;
    result.payload_valid  = 1'b0;
    result.payload_byte   = '0;
    result.frame_status   = wscu_pkg::ST_BUSY;
    result.payload_length = (pos_r >= 8'd2) ? flen_r : '0;

    if (err_r) begin
      result.frame_status = wscu_pkg::ST_BUSY;
    end else if (pos_r == 8'd0) begin
      if (data_byte != wscu_pkg::FirstByte) begin
        result.frame_status = wscu_pkg::ST_BAD_FIRST;
        err_nxt = 1'b1;
      end else if (block_end) begin
        result.frame_status = wscu_pkg::ST_UNMASKED;
        err_nxt = 1'b1;
      end
    end else if (pos_r == 8'd1) begin
      result.payload_length = data_byte[wscu_pkg::LenW-1:0];
      flen_nxt = data_byte[wscu_pkg::LenW-1:0];
      if ((data_byte & wscu_pkg::MaskBit) == '0) begin
        result.frame_status = wscu_pkg::ST_UNMASKED;
        err_nxt = 1'b1;
      end else if (data_byte[wscu_pkg::LenW-1:0] > wscu_pkg::MaxLen) begin
        result.frame_status = wscu_pkg::ST_TOO_LONG;
        err_nxt = 1'b1;
      end else if (block_end) begin
        result.frame_status = wscu_pkg::ST_NO_MASK;
        err_nxt = 1'b1;
      end
    end else if (pos_r < wscu_pkg::HdrBytes) begin
      key_nxt[{hdr_idx, 3'b000} +: wscu_pkg::ByteW] = data_byte;
      if (pos_r == wscu_pkg::HdrBytes - 8'd1) begin
        if (flen_r == '0) begin
          result.frame_status = wscu_pkg::ST_DONE;
        end else if (block_end) begin
          result.frame_status = wscu_pkg::ST_TRUNC;
          err_nxt = 1'b1;
        end
      end else if (block_end) begin
        result.frame_status = wscu_pkg::ST_NO_MASK;
        err_nxt = 1'b1;
      end
    end else if (pos_r < pay_end) begin
      result.payload_valid = 1'b1;
      result.payload_byte  = data_byte ^ key_byte;
      if (pos_r + 8'd1 == pay_end) begin
        result.frame_status = wscu_pkg::ST_DONE;
      end else if (block_end) begin
        result.frame_status = wscu_pkg::ST_TRUNC;
        err_nxt = 1'b1;
      end
    end else begin
      result.frame_status = wscu_pkg::ST_DONE;
    end

    if (pos_r != wscu_pkg::PosMax) begin
      pos_nxt = pos_r + 8'd1;
    end
    if (block_end) begin
      pos_nxt  = '0;
      flen_nxt = '0;
      key_nxt  = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      flen_r <= '0;
      key_r  <= '0;
      err_r  <= 1'b0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      flen_r <= flen_nxt;
      key_r  <= key_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

@@ hdl/wscu_checker.sv @@
module wscu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [wscu_pkg::OutDataW-1:0] out_tdata,
  input logic                          out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // payload byte only with busy, done or truncated
  a_pay_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[10:8] == wscu_pkg::ST_BUSY) ||
      (out_tdata[10:8] == wscu_pkg::ST_DONE) ||
      (out_tdata[10:8] == wscu_pkg::ST_TRUNC))
    else $error("payload byte with error status");

  // non-payload results carry a zero byte and a defined status
  a_nopay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'h00)
    else $error("nonzero byte without payload flag");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:8] != 3'd7 && out_tdata[23:18] == 6'd0)
    else $error("bad status code or fill bits");

  // empty result slot never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result slot");

endmodule

bind websocket_close_frame_unmask wscu_checker u_wscu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned PhaseItems = 350;   // five phases, ~1750 bytes total
  localparam int unsigned HoldCycles = 300;   // long output back-pressure
  localparam int unsigned IdleLimit  = 4000;  // watchdog: cycles w/o any request
  localparam int unsigned DrainWait  = 20;    // generous margin for the pipe to drain

  typedef struct packed {
    logic [wscu_pkg::ByteW-1:0] data_byte;
    logic                       block_end;
  } rx_req_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = '0;
  logic                          in_tlast   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [wscu_pkg::OutDataW-1:0] out_tdata;
  logic                          out_tuser;

  // Stimulus and scoreboard storage
  rx_req_t                    pending_bytes[$];
  wscu_pkg::result_t          expected_results[$];
  logic [wscu_pkg::ByteW-1:0] block_buf[$];

  // Predictor state, mirrors the parser registers
  logic [wscu_pkg::PosW-1:0]  unm_pos = '0;
  logic [wscu_pkg::LenW-1:0]  unm_len = '0;
  logic [wscu_pkg::KeyW-1:0]  unm_key = '0;
  logic                       unm_err = 1'b0;

  // Traffic shaping; the sequencer writes the percentages and hold_reqs at falling edges only
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  int unsigned       errors     = 0;
  int unsigned       idle_count = 0;
  rx_req_t           next_req;
  wscu_pkg::result_t want;

  websocket_close_frame_unmask dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One step of the frame parser: returns the result for this byte and
  // advances the predictor state.
  function automatic wscu_pkg::result_t predict_unmask(
      input logic [wscu_pkg::ByteW-1:0] b, input logic is_last);
    wscu_pkg::result_t r;
    int unsigned       key_idx;
    int unsigned       pay_idx;
    r.payload_valid  = 1'b0;
    r.payload_byte   = '0;
    r.frame_status   = wscu_pkg::ST_BUSY;
    r.payload_length = (unm_pos >= 2) ? unm_len : '0;
    if (unm_err) begin
      r.frame_status = wscu_pkg::ST_BUSY;
    end else if (unm_pos == 0) begin
      if (b != wscu_pkg::FirstByte) begin
        r.frame_status = wscu_pkg::ST_BAD_FIRST;
        unm_err = 1'b1;
      end else if (is_last) begin
        r.frame_status = wscu_pkg::ST_UNMASKED;
        unm_err = 1'b1;
      end
    end else if (unm_pos == 1) begin
      r.payload_length = b[wscu_pkg::LenW-1:0];
      if ((b & wscu_pkg::MaskBit) == '0) begin
        r.frame_status = wscu_pkg::ST_UNMASKED;
        unm_err = 1'b1;
      end else if (b[wscu_pkg::LenW-1:0] > wscu_pkg::MaxLen) begin
        r.frame_status = wscu_pkg::ST_TOO_LONG;
        unm_err = 1'b1;
      end else if (is_last) begin
        r.frame_status = wscu_pkg::ST_NO_MASK;
        unm_err = 1'b1;
      end
      unm_len = b[wscu_pkg::LenW-1:0];
    end else if (unm_pos < wscu_pkg::HdrBytes) begin
      key_idx = int'(unm_pos) - 2;
      unm_key[8*key_idx +: 8] = b;
      if (unm_pos == wscu_pkg::HdrBytes - 1) begin
        // last key byte: an empty payload finishes the frame here
        if (unm_len == 0) begin
          r.frame_status = wscu_pkg::ST_DONE;
        end else if (is_last) begin
          r.frame_status = wscu_pkg::ST_TRUNC;
          unm_err = 1'b1;
        end
      end else if (is_last) begin
        r.frame_status = wscu_pkg::ST_NO_MASK;
        unm_err = 1'b1;
      end
    end else if (int'(unm_pos) < int'(wscu_pkg::HdrBytes) + int'(unm_len)) begin
      pay_idx = int'(unm_pos) - int'(wscu_pkg::HdrBytes);
      r.payload_valid = 1'b1;
      r.payload_byte  = b ^ unm_key[8*(pay_idx % 4) +: 8];
      if (pay_idx + 1 == int'(unm_len)) begin
        r.frame_status = wscu_pkg::ST_DONE;
      end else if (is_last) begin
        r.frame_status = wscu_pkg::ST_TRUNC;
        unm_err = 1'b1;
      end
    end else begin
      r.frame_status = wscu_pkg::ST_DONE;   // trailing bytes past the payload
    end
    if (unm_pos != wscu_pkg::PosMax) unm_pos = unm_pos + 1'b1;
    if (is_last) begin
      unm_pos = '0;
      unm_len = '0;
      unm_key = '0;
      unm_err = 1'b0;
    end
    return r;
  endfunction

  // Moves block_buf to the send queue, tlast on its final byte.
  task automatic flush_block();
    rx_req_t r;
    for (int i = 0; i < block_buf.size(); i++) begin
      r.data_byte = block_buf[i];
      r.block_end = (i == block_buf.size() - 1);
      pending_bytes.push_back(r);
    end
    block_buf.delete();
  endtask

  // Mostly well-formed close frames with random key and payload, the rest
  // truncated, corrupted header, oversize length, noise or very long blocks.
  task automatic add_random_block();
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    int unsigned n;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(12);
    block_buf.delete();
    block_buf.push_back(wscu_pkg::FirstByte);
    block_buf.push_back(wscu_pkg::MaskBit | 8'(len));
    repeat (4 + len) block_buf.push_back(8'($urandom));
    if (kind < 72) begin
      if ($urandom_range(2) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) block_buf.push_back(8'($urandom));
      end
    end else if (kind < 82) begin
      cut = $urandom_range(1, block_buf.size() - 1);
      while (block_buf.size() > cut) void'(block_buf.pop_back());
    end else if (kind < 87) begin
      block_buf[0] = 8'($urandom);
      if (block_buf[0] == wscu_pkg::FirstByte) block_buf[0][0] = 1'b1;
    end else if (kind < 91) begin
      block_buf[1][7] = 1'b0;
    end else if (kind < 95) begin
      block_buf[1] = wscu_pkg::MaskBit | 8'($urandom_range(126, 127));
    end else if (kind < 99) begin
      n = $urandom_range(1, 8);
      block_buf.delete();
      repeat (n) block_buf.push_back(8'($urandom));
      if ($urandom_range(1) == 0) block_buf[0] = wscu_pkg::FirstByte;
    end else begin
      // run the position counter into saturation
      n = 260 - block_buf.size() + $urandom_range(20);
      repeat (n) block_buf.push_back(8'($urandom));
    end
    flush_block();
  endtask

  // Header extremes and every status code at least once.
  task automatic add_directed_blocks();
    block_buf = {8'h00, 8'hFF};                              // bad first byte, then ignored
    flush_block();
    block_buf = {wscu_pkg::FirstByte};                       // block ends after byte 0
    flush_block();
    block_buf = {wscu_pkg::FirstByte, 8'h7F};                // mask bit clear
    flush_block();
    block_buf = {wscu_pkg::FirstByte, 8'hFF, 8'h00};         // length 127
    flush_block();
    block_buf = {wscu_pkg::FirstByte, 8'hFD};                // ends before the key
    flush_block();
    block_buf = {wscu_pkg::FirstByte, 8'h80, 8'hAA, 8'h55, 8'hFF, 8'h00}; // empty payload
    flush_block();
    block_buf = {wscu_pkg::FirstByte, 8'h82, 8'hFF, 8'h00, 8'hAA, 8'h55,
                 8'h00};                                     // truncated
    flush_block();
    block_buf = {wscu_pkg::FirstByte, 8'h81, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'hFF,
                 8'h12};
    flush_block();                                           // done, then trailing byte
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Driver: predicts on each accepted request, then presents the next byte
  // unless it rolls an idle cycle. Valid is written once per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_unmask(in_tdata, in_tlast));
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req  = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_req.data_byte;
          in_tlast  <= next_req.block_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: out_tdata = {zero fill, payload_length, frame_status, payload_byte}
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata=%h tuser=%b", out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("payload_valid", want.payload_valid, out_tuser);
        check_field("payload_byte", want.payload_byte, out_tdata[7:0]);
        check_field("frame_status", want.frame_status, out_tdata[10:8]);
        check_field("payload_length", want.payload_length, out_tdata[17:11]);
      end
    end
  end

  // Watchdog: a stuck handshake on either side ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Sequencer: phases of idling patterns, each drained before the next
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 0) add_directed_blocks();
      while (pending_bytes.size() < PhaseItems) add_random_block();
      // last phase: stall the output long enough to back up the input
      if (ph == 4) hold_reqs++;
      while (pending_bytes.size() != 0 || in_tvalid) @(negedge clk);
      while (expected_results.size() != 0) @(negedge clk);
    end
    repeat (DrainWait) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
